/* src/sme_pkg.sv */
// shared constants for the stack machine instruction executor
// opcodes, status codes, result kinds and sizing defaults; no dependencies
package sme_pkg;

  localparam int StackDepth   = 16;
  localparam int ProgramWords = 4096;
  localparam int NumRegs      = 32;

  localparam logic [5:0] OpHalt  = 6'd0;
  localparam logic [5:0] OpDisp  = 6'd1;
  localparam logic [5:0] OpPrint = 6'd2;
  localparam logic [5:0] OpPush  = 6'd10;
  localparam logic [5:0] OpPop   = 6'd11;
  localparam logic [5:0] OpMov   = 6'd12;
  localparam logic [5:0] OpCall  = 6'd20;
  localparam logic [5:0] OpRet   = 6'd21;
  localparam logic [5:0] OpJmp   = 6'd22;
  localparam logic [5:0] OpJz    = 6'd23;
  localparam logic [5:0] OpJpos  = 6'd24;
  localparam logic [5:0] OpJneg  = 6'd25;
  localparam logic [5:0] OpAdd   = 6'd30;
  localparam logic [5:0] OpSub   = 6'd31;
  localparam logic [5:0] OpMul   = 6'd32;
  localparam logic [5:0] OpDiv   = 6'd33;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StHalted = 3'd1;
  localparam logic [2:0] StFull   = 3'd2;
  localparam logic [2:0] StEmpty  = 3'd3;
  localparam logic [2:0] StOvf    = 3'd4;
  localparam logic [2:0] StUnf    = 3'd5;
  localparam logic [2:0] StDivZ   = 3'd6;
  localparam logic [2:0] StBadOp  = 3'd7;

  localparam logic [1:0] KindReg   = 2'd0;
  localparam logic [1:0] KindStack = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;

endpackage

/* src/sme_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module sme_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/stack_machine_instruction_executor_unit.sv */
// stack machine instruction executor: sequencer, register file, stack, divider
// depends on sme_pkg and sme_ram
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | opcode, reg_a, reg_b, target, entry_count, immediate
//  out     | output    | out_valid_o/out_ready_i | kind, value, slot_label, next_ip, status, last
//  cfg     | input     | cfg_we_i              | cfg_wdata_i (program_length)
//
// one instruction at a time; ready only while the sequencer is idle
// print reads and emits the stack one entry at a time,
// div works through the divider (one quotient bit per cycle)
// register file and stack are rams read one address per cycle
// output register frees the sequencer while a result waits; a stall holds it
module stack_machine_instruction_executor_unit #(
  parameter int STACK_DEPTH = sme_pkg::StackDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  opcode_i,
  input  logic [4:0]  reg_a_i,
  input  logic [4:0]  reg_b_i,
  input  logic [11:0] target_i,
  input  logic [6:0]  entry_count_i,
  input  logic signed [31:0] immediate_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic signed [31:0] value_o,
  output logic [5:0]  slot_label_o,
  output logic [11:0] next_ip_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam int Sw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int Dw = $clog2(STACK_DEPTH + 1);
  localparam logic [Dw-1:0] FullCnt = Dw'(STACK_DEPTH);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SDec  = 4'd1;
  localparam logic [3:0] SDisp = 4'd2;
  localparam logic [3:0] SPush = 4'd3;
  localparam logic [3:0] SPop  = 4'd4;
  localparam logic [3:0] SRdB  = 4'd5;
  localparam logic [3:0] SArB  = 4'd6;
  localparam logic [3:0] SDiv  = 4'd7;
  localparam logic [3:0] SDivF = 4'd8;
  localparam logic [3:0] SChk  = 4'd9;
  localparam logic [3:0] SPrd  = 4'd10;
  localparam logic [3:0] SPem  = 4'd11;
  localparam logic [3:0] SCmpl = 4'd12;

  logic [3:0]  state_q, state_d;
  logic [12:0] plen_q, plen_d;
  logic [11:0] ip_q, ip_d;
  logic        halted_q, halted_d;
  logic [Dw-1:0] depth_q, depth_d;
  logic [31:0] rf_vld_q, rf_vld_d;
  logic        rd_vld_q, rd_vld_d;

  logic [5:0]  op_q, op_d;
  logic [4:0]  ra_q, ra_d;
  logic [4:0]  rb_q, rb_d;
  logic [11:0] tgt_q, tgt_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] imm_q, imm_d;

  logic [2:0]  st_q, st_d;
  logic [11:0] nip_q, nip_d;
  logic [31:0] a_q, a_d;
  logic [63:0] res_q, res_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dsr_q, dsr_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic        dneg_q, dneg_d;
  logic [Dw-1:0] pidx_q, pidx_d;
  logic [6:0]  plab_q, plab_d;

  logic        ov_q, ov_d;
  logic [1:0]  kind_q, kind_d;
  logic [31:0] val_q, val_d;
  logic [5:0]  lab_q, lab_d;
  logic [11:0] onip_q, onip_d;
  logic [2:0]  ost_q, ost_d;
  logic        last_q, last_d;

  logic        rf_we, rf_re;
  logic [4:0]  rf_waddr, rf_raddr;
  logic [31:0] rf_wdata, rf_rdata, rf_val;
  logic        sk_we, sk_re;
  logic [Sw-1:0] sk_waddr, sk_raddr;
  logic [31:0] sk_wdata, sk_rdata;

  logic        can_emit, full, empty, beyond;
  logic [11:0] ip2, ip3;
  logic [Dw-1:0] dm1, pm1;
  logic [32:0] rem_sh;
  logic [31:0] quo_nx;
  logic [63:0] qext;

  sme_ram #(.Width(32), .Depth(sme_pkg::NumRegs)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .re_i(rf_re), .raddr_i(rf_raddr), .rdata_o(rf_rdata)
  );

  sme_ram #(.Width(32), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(sk_we), .waddr_i(sk_waddr), .wdata_i(sk_wdata),
    .re_i(sk_re), .raddr_i(sk_raddr), .rdata_o(sk_rdata)
  );

  assign in_ready_o   = (state_q == SIdle);
  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign value_o      = val_q;
  assign slot_label_o = lab_q;
  assign next_ip_o    = onip_q;
  assign status_o     = ost_q;
  assign last_o       = last_q;

  assign can_emit = !ov_q || out_ready_i;
  assign full     = (depth_q == FullCnt);
  assign empty    = (depth_q == '0);
  assign dm1      = depth_q - Dw'(1);
  assign pm1      = pidx_q - Dw'(1);
  assign ip2      = ip_q + 12'd2;
  assign ip3      = ip_q + 12'd3;
  assign beyond   = (17'(ip_q) >= 17'(plen_q)) || (17'(ip_q) >= 17'(sme_pkg::ProgramWords));
  assign rf_val   = rd_vld_q ? rf_rdata : 32'd0;
  assign rem_sh   = {rem_q[31:0], quo_q[31]};
  assign quo_nx   = {quo_q[30:0], (rem_sh >= {1'b0, dsr_q})};
  assign qext     = {32'd0, quo_q};

  always_comb begin
    state_d = state_q; plen_d = plen_q; ip_d = ip_q; halted_d = halted_q;
    depth_d = depth_q; rf_vld_d = rf_vld_q; rd_vld_d = rd_vld_q;
    op_d = op_q; ra_d = ra_q; rb_d = rb_q; tgt_d = tgt_q; cnt_d = cnt_q; imm_d = imm_q;
    st_d = st_q; nip_d = nip_q; a_d = a_q; res_d = res_q;
    rem_d = rem_q; quo_d = quo_q; dsr_d = dsr_q; dcnt_d = dcnt_q; dneg_d = dneg_q;
    pidx_d = pidx_q; plab_d = plab_q;
    ov_d = ov_q && !out_ready_i;
    kind_d = kind_q; val_d = val_q; lab_d = lab_q; onip_d = onip_q;
    ost_d = ost_q; last_d = last_q;
    rf_we = 1'b0; rf_waddr = ra_q; rf_wdata = imm_q;
    rf_re = 1'b0; rf_raddr = ra_q;
    sk_we = 1'b0; sk_waddr = depth_q[Sw-1:0]; sk_wdata = 32'(ip2);
    sk_re = 1'b0; sk_raddr = dm1[Sw-1:0];

    if (cfg_we_i) begin
      plen_d = cfg_wdata_i;
    end

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          op_d = opcode_i; ra_d = reg_a_i; rb_d = reg_b_i; tgt_d = target_i;
          cnt_d = entry_count_i; imm_d = immediate_i;
          state_d = SDec;
        end
      end
      SDec: begin
        st_d = sme_pkg::StOk;
        nip_d = ip_q;
        state_d = SCmpl;
        if (halted_q || beyond) begin
          st_d = sme_pkg::StHalted;
        end else begin
          unique case (op_q)
            sme_pkg::OpHalt: st_d = sme_pkg::StHalted;
            sme_pkg::OpDisp: begin
              nip_d = ip2; rf_re = 1'b1; rd_vld_d = rf_vld_q[ra_q]; state_d = SDisp;
            end
            sme_pkg::OpPrint: begin
              pidx_d = depth_q; plab_d = cnt_q;
              if (cnt_q > 7'(depth_q)) begin
                st_d = sme_pkg::StEmpty;
              end else begin
                nip_d = ip2;
              end
              if (!empty && cnt_q != 7'd0) begin
                state_d = SPrd;
              end
            end
            sme_pkg::OpPush: begin
              if (full) begin
                st_d = sme_pkg::StFull;
              end else begin
                nip_d = ip2; rf_re = 1'b1; rd_vld_d = rf_vld_q[ra_q]; state_d = SPush;
              end
            end
            sme_pkg::OpCall: begin
              if (full) begin
                st_d = sme_pkg::StFull;
              end else begin
                sk_we = 1'b1; depth_d = depth_q + Dw'(1); nip_d = tgt_q;
              end
            end
            sme_pkg::OpPop, sme_pkg::OpRet, sme_pkg::OpJz, sme_pkg::OpJpos,
            sme_pkg::OpJneg: begin
              if (empty) begin
                st_d = sme_pkg::StEmpty;
              end else begin
                sk_re = 1'b1; state_d = SPop;
              end
            end
            sme_pkg::OpMov: begin
              rf_we = 1'b1; rf_vld_d[ra_q] = 1'b1; nip_d = ip3;
            end
            sme_pkg::OpJmp: nip_d = tgt_q;
            sme_pkg::OpAdd, sme_pkg::OpSub, sme_pkg::OpMul, sme_pkg::OpDiv: begin
              rf_re = 1'b1; rd_vld_d = rf_vld_q[ra_q]; state_d = SRdB;
            end
            default: st_d = sme_pkg::StBadOp;
          endcase
        end
      end
      SDisp: begin
        if (can_emit) begin
          ov_d = 1'b1; kind_d = sme_pkg::KindReg; val_d = rf_val; lab_d = 6'd0;
          onip_d = nip_q; ost_d = st_q; last_d = 1'b0;
          state_d = SCmpl;
        end
      end
      SPush: begin
        sk_we = 1'b1; sk_wdata = rf_val; depth_d = depth_q + Dw'(1);
        state_d = SCmpl;
      end
      SPop: begin
        depth_d = dm1;
        nip_d = ip2;
        if (op_q == sme_pkg::OpPop) begin
          rf_we = 1'b1; rf_wdata = sk_rdata; rf_vld_d[ra_q] = 1'b1;
        end else if (op_q == sme_pkg::OpRet) begin
          nip_d = sk_rdata[11:0];
        end else if ((op_q == sme_pkg::OpJz && sk_rdata == 32'd0) ||
                     (op_q == sme_pkg::OpJpos && !sk_rdata[31] && sk_rdata != 32'd0) ||
                     (op_q == sme_pkg::OpJneg && sk_rdata[31])) begin
          nip_d = tgt_q;
        end
        state_d = SCmpl;
      end
      SRdB: begin
        a_d = rf_val; rf_re = 1'b1; rf_raddr = rb_q; rd_vld_d = rf_vld_q[rb_q];
        state_d = SArB;
      end
      SArB: begin
        state_d = SChk;
        unique case (op_q)
          sme_pkg::OpAdd: res_d = {{32{a_q[31]}}, a_q} + {{32{rf_val[31]}}, rf_val};
          sme_pkg::OpSub: res_d = {{32{a_q[31]}}, a_q} - {{32{rf_val[31]}}, rf_val};
          sme_pkg::OpMul: res_d = 64'($signed(a_q) * $signed(rf_val));
          default: begin
            if (rf_val == 32'd0) begin
              st_d = sme_pkg::StDivZ; state_d = SCmpl;
            end else begin
              dneg_d = a_q[31] ^ rf_val[31];
              quo_d = a_q[31] ? -a_q : a_q;
              dsr_d = rf_val[31] ? -rf_val : rf_val;
              rem_d = '0; dcnt_d = '0; state_d = SDiv;
            end
          end
        endcase
      end
      SDiv: begin
        rem_d = (rem_sh >= {1'b0, dsr_q}) ? rem_sh - {1'b0, dsr_q} : rem_sh;
        quo_d = quo_nx;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = SDivF;
        end
      end
      SDivF: begin
        res_d = dneg_q ? -qext : qext;
        state_d = SChk;
      end
      SChk: begin
        state_d = SCmpl;
        if (!res_q[63] && (res_q[62:31] != '0)) begin
          st_d = sme_pkg::StOvf;
        end else if (res_q[63] && (res_q[62:31] != '1)) begin
          st_d = sme_pkg::StUnf;
        end else if (full) begin
          st_d = sme_pkg::StFull;
        end else begin
          sk_we = 1'b1; sk_wdata = res_q[31:0]; depth_d = depth_q + Dw'(1);
          nip_d = ip3;
        end
      end
      SPrd: begin
        sk_re = 1'b1; sk_raddr = pm1[Sw-1:0];
        state_d = SPem;
      end
      SPem: begin
        if (can_emit) begin
          ov_d = 1'b1; kind_d = sme_pkg::KindStack; val_d = sk_rdata;
          lab_d = 6'(plab_q - 7'd1); onip_d = nip_q; ost_d = st_q; last_d = 1'b0;
          pidx_d = pm1; plab_d = plab_q - 7'd1;
          state_d = (pm1 != '0 && plab_q != 7'd1) ? SPrd : SCmpl;
        end
      end
      SCmpl: begin
        if (can_emit) begin
          ov_d = 1'b1; kind_d = sme_pkg::KindDone; val_d = 32'd0; lab_d = 6'd0;
          onip_d = nip_q; ost_d = st_q; last_d = 1'b1;
          ip_d = nip_q;
          halted_d = halted_q || (st_q != sme_pkg::StOk);
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; plen_q <= 13'd4096; ip_q <= '0; halted_q <= 1'b0;
      depth_q <= '0; rf_vld_q <= '0; rd_vld_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; plen_q <= plen_d; ip_q <= ip_d; halted_q <= halted_d;
      depth_q <= depth_d; rf_vld_q <= rf_vld_d; rd_vld_q <= rd_vld_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; ra_q <= ra_d; rb_q <= rb_d; tgt_q <= tgt_d; cnt_q <= cnt_d; imm_q <= imm_d;
    st_q <= st_d; nip_q <= nip_d; a_q <= a_d; res_q <= res_d;
    rem_q <= rem_d; quo_q <= quo_d; dsr_q <= dsr_d; dcnt_q <= dcnt_d; dneg_q <= dneg_d;
    pidx_q <= pidx_d; plab_q <= plab_d;
    kind_q <= kind_d; val_q <= val_d; lab_q <= lab_d; onip_q <= onip_d;
    ost_q <= ost_d; last_q <= last_d;
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for stack_machine_instruction_executor_unit
// drives instruction transactions, predicts every result in a local machine model, checks them
// depends on sme_pkg and the executor rtl only
module tb;
  import sme_pkg::*;

  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [11:0] tgt;
    logic [6:0]  cnt;
    logic [31:0] imm;
  } instr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [5:0]  label;
    logic [11:0] nip;
    logic [2:0]  status;
    logic        last;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        tx_valid;
  logic        in_ready_o;
  instr_t      tx_item;
  logic        out_valid_o;
  logic        rx_ready;
  logic [1:0]  kind_o;
  logic signed [31:0] value_o;
  logic [5:0]  slot_label_o;
  logic [11:0] next_ip_o;
  logic [2:0]  status_o;
  logic        last_o;

  stack_machine_instruction_executor_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(tx_valid), .in_ready_o(in_ready_o),
    .opcode_i(tx_item.op), .reg_a_i(tx_item.ra), .reg_b_i(tx_item.rb),
    .target_i(tx_item.tgt), .entry_count_i(tx_item.cnt), .immediate_i(tx_item.imm),
    .out_valid_o(out_valid_o), .out_ready_i(rx_ready),
    .kind_o(kind_o), .value_o(value_o), .slot_label_o(slot_label_o),
    .next_ip_o(next_ip_o), .status_o(status_o), .last_o(last_o)
  );

  always #5 clk_i = ~clk_i;

  // machine model
  logic [31:0] regs_m[NumRegs];
  logic [31:0] stk_m[StackDepth];
  int          depth_m;
  logic [11:0] ip_m;
  bit          halt_m;
  int          plen_m;

  instr_t pending_q[$];
  res_t   result_q[$];
  int     n_fail, n_items, n_results, n_full_prints;

  function automatic int lim_m();
    return (plen_m < ProgramWords) ? plen_m : ProgramWords;
  endfunction

  function automatic void add_res(ref res_t rs[$], input logic [1:0] k, input logic [31:0] v,
                                  input logic [5:0] lab);
    res_t e;
    e = '0;
    e.kind = k;
    e.value = v;
    e.label = lab;
    rs.push_back(e);
  endfunction

  function automatic void exec_instr(input instr_t it, ref res_t rs[$]);
    logic [11:0] ip;
    logic [2:0]  st;
    longint      x, y, r;
    logic [31:0] v;
    int          d, lab, first;
    ip = ip_m;
    st = StOk;
    r = 0;
    first = rs.size();
    if (!halt_m && ip_m >= lim_m()) halt_m = 1;
    if (halt_m) begin
      st = StHalted;
    end else begin
      case (it.op)
        OpHalt: st = StHalted;
        OpDisp: begin
          add_res(rs, KindReg, regs_m[it.ra], 6'd0);
          ip = ip + 12'd2;
        end
        OpPrint: begin
          d = depth_m;
          lab = it.cnt;
          while (d > 0 && lab > 0) begin
            d--;
            lab--;
            add_res(rs, KindStack, stk_m[d], lab[5:0]);
          end
          if (lab > 0) st = StEmpty;
          else ip = ip + 12'd2;
        end
        OpPush, OpCall: begin
          if (depth_m >= StackDepth) begin
            st = StFull;
          end else begin
            stk_m[depth_m] = (it.op == OpPush) ? regs_m[it.ra] : {20'd0, ip + 12'd2};
            depth_m++;
            ip = (it.op == OpPush) ? ip + 12'd2 : it.tgt;
          end
        end
        OpPop, OpRet, OpJz, OpJpos, OpJneg: begin
          if (depth_m == 0) begin
            st = StEmpty;
          end else begin
            depth_m--;
            v = stk_m[depth_m];
            x = longint'(signed'(v));
            if (it.op == OpPop) begin
              regs_m[it.ra] = v;
              ip = ip + 12'd2;
            end else if (it.op == OpRet) begin
              ip = v[11:0];
            end else if ((it.op == OpJz && x == 0) || (it.op == OpJpos && x > 0) ||
                         (it.op == OpJneg && x < 0)) begin
              ip = it.tgt;
            end else begin
              ip = ip + 12'd2;
            end
          end
        end
        OpMov: begin
          regs_m[it.ra] = it.imm;
          ip = ip + 12'd3;
        end
        OpJmp: ip = it.tgt;
        OpAdd, OpSub, OpMul, OpDiv: begin
          x = longint'(signed'(regs_m[it.ra]));
          y = longint'(signed'(regs_m[it.rb]));
          if (it.op == OpAdd) r = x + y;
          else if (it.op == OpSub) r = x - y;
          else if (it.op == OpMul) r = x * y;
          else if (y == 0) st = StDivZ;
          else r = x / y;
          if (st == StOk) begin
            if (r > 64'sd2147483647) st = StOvf;
            else if (r < -64'sd2147483648) st = StUnf;
            else if (depth_m >= StackDepth) st = StFull;
            else begin
              stk_m[depth_m] = r[31:0];
              depth_m++;
              ip = ip + 12'd3;
            end
          end
        end
        default: st = StBadOp;
      endcase
      if (st != StOk) halt_m = 1;
      ip_m = ip;
    end
    add_res(rs, KindDone, 32'd0, 6'd0);
    for (int i = first; i < rs.size(); i++) begin
      rs[i].nip = ip_m;
      rs[i].status = st;
      rs[i].last = (i == rs.size() - 1);
    end
  endfunction

  function automatic instr_t mk(logic [5:0] op, logic [4:0] ra, logic [4:0] rb,
                                logic [11:0] tgt, logic [6:0] cnt, logic [31:0] imm);
    instr_t it;
    it = '{op: op, ra: ra, rb: rb, tgt: tgt, cnt: cnt, imm: imm};
    return it;
  endfunction

  // commit regardless of outcome
  task automatic issue_raw(input instr_t it);
    res_t rs[$];
    exec_instr(it, rs);
    pending_q.push_back(it);
    foreach (rs[i]) result_q.push_back(rs[i]);
  endtask

  // commit only if the machine stays running with the pointer in range
  task automatic issue_ok(input instr_t it, output bit ok);
    logic [31:0] regs_s[NumRegs];
    logic [31:0] stk_s[StackDepth];
    int          depth_s;
    logic [11:0] ip_s;
    res_t        rs[$];
    if (ip_m + 4 >= lim_m())
      issue_raw(mk(OpJmp, 5'($urandom), 5'($urandom), 12'($urandom_range(0, lim_m() / 2)),
                   7'($urandom), $urandom));
    regs_s = regs_m;
    stk_s = stk_m;
    depth_s = depth_m;
    ip_s = ip_m;
    exec_instr(it, rs);
    ok = (rs[rs.size() - 1].status == StOk) && (ip_m < lim_m());
    if (ok) begin
      pending_q.push_back(it);
      foreach (rs[i]) result_q.push_back(rs[i]);
      if (it.op == OpPrint && it.cnt == StackDepth) n_full_prints++;
    end else begin
      regs_m = regs_s;
      stk_m = stk_s;
      depth_m = depth_s;
      ip_m = ip_s;
      halt_m = 0;
    end
  endtask

  task automatic go(input instr_t it);
    bit ok;
    issue_ok(it, ok);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || tx_valid || result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_plen(input int val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 13'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    plen_m = val & 13'h1fff;
  endtask

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'd0 : 32'hffffffff;
      3: return 32'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] rand_op();
    logic [5:0] ops[16] = '{OpDisp, OpPrint, OpPush, OpPush, OpPop, OpMov, OpMov, OpCall,
                            OpRet, OpJmp, OpJz, OpJpos, OpJneg, OpAdd, OpSub, OpMul};
    if ($urandom_range(0, 15) == 0) return OpDiv;
    return ops[$urandom_range(0, 15)];
  endfunction

  function automatic bit known_op(logic [5:0] op);
    case (op)
      OpHalt, OpDisp, OpPrint, OpPush, OpPop, OpMov, OpCall, OpRet, OpJmp, OpJz, OpJpos,
      OpJneg, OpAdd, OpSub, OpMul, OpDiv: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic random_run(input int count);
    instr_t it;
    bit     ok;
    int     done;
    done = 0;
    while (done < count) begin
      it = instr_t'({$urandom, $urandom, $urandom});
      it.op = rand_op();
      it.tgt = 12'($urandom_range(0, lim_m() - 1));
      it.cnt = 7'($urandom_range(0, depth_m));
      if ($urandom_range(0, 3) == 0) it.cnt = 7'(depth_m);
      it.imm = rand_imm();
      issue_ok(it, ok);
      if (ok) done++;
    end
  endtask

  // sender: bursts with random gaps
  int burst_left, gap_left;
  instr_t next_item;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      tx_item <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (tx_valid && in_ready_o) n_items++;
      if (!tx_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          tx_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          next_item = pending_q.pop_front();
          tx_item <= next_item;
          tx_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          tx_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall pattern, picked anew from the rx_cycle counter
  int rx_cycle, rx_mode;
  res_t exp_r;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
      rx_cycle = 0;
      rx_mode = 0;
    end else begin
      if (out_valid_o && rx_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $error("unexpected result transaction kind=%0d value=%0d", kind_o, value_o);
          n_fail++;
        end else begin
          exp_r = result_q.pop_front();
          if (kind_o !== exp_r.kind) begin
            $error("kind: expected %0d actual %0d", exp_r.kind, kind_o); n_fail++;
          end
          if (value_o !== exp_r.value) begin
            $error("value: expected %0d actual %0d", $signed(exp_r.value), value_o); n_fail++;
          end
          if (slot_label_o !== exp_r.label) begin
            $error("slot_label: expected %0d actual %0d", exp_r.label, slot_label_o); n_fail++;
          end
          if (next_ip_o !== exp_r.nip) begin
            $error("next_ip: expected %0d actual %0d", exp_r.nip, next_ip_o); n_fail++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d actual %0d", exp_r.status, status_o); n_fail++;
          end
          if (last_o !== exp_r.last) begin
            $error("last: expected %0d actual %0d", exp_r.last, last_o); n_fail++;
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: rx_ready <= 1'b1;
        1: rx_ready <= ($urandom_range(0, 3) != 0);
        default: rx_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("stack_machine_instruction_executor_unit test failed");
    $finish;
  end

  initial begin
    int err_sel;
    instr_t it;
    foreach (regs_m[i]) regs_m[i] = '0;
    foreach (stk_m[i]) stk_m[i] = '0;
    depth_m = 0;
    ip_m = '0;
    halt_m = 0;
    plen_m = ProgramWords;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and every opcode but halt
    write_plen(13'h1fff);
    go(mk(OpMov, 5'd31, 5'd0, 12'd0, 7'd0, 32'h7fffffff));
    go(mk(OpMov, 5'd0, 5'd0, 12'd0, 7'd0, 32'h80000000));
    go(mk(OpMov, 5'd1, 5'd0, 12'd0, 7'd0, 32'hffffffff));
    go(mk(OpMov, 5'd2, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpDisp, 5'd31, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpDisp, 5'd0, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpAdd, 5'd31, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpSub, 5'd0, 5'd2, 12'd0, 7'd0, 32'd0));
    go(mk(OpMul, 5'd31, 5'd1, 12'd0, 7'd0, 32'd0));
    go(mk(OpDiv, 5'd0, 5'd31, 12'd0, 7'd0, 32'd0));
    go(mk(OpPrint, 5'd0, 5'd0, 12'd0, 7'(depth_m), 32'd0));
    go(mk(OpPrint, 5'd0, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpPop, 5'd5, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpPush, 5'd2, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpJz, 5'd0, 5'd0, 12'd200, 7'd0, 32'd0));
    go(mk(OpPush, 5'd1, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpJneg, 5'd0, 5'd0, 12'd300, 7'd0, 32'd0));
    go(mk(OpPush, 5'd31, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpJpos, 5'd0, 5'd0, 12'd400, 7'd0, 32'd0));
    go(mk(OpPush, 5'd2, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpJpos, 5'd0, 5'd0, 12'd500, 7'd0, 32'd0));
    go(mk(OpCall, 5'd0, 5'd0, 12'd4000, 7'd0, 32'd0));
    go(mk(OpRet, 5'd0, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpJmp, 5'd0, 5'd0, 12'd4094, 7'd0, 32'd0));
    go(mk(OpDisp, 5'd5, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpJmp, 5'd0, 5'd0, 12'd4093, 7'd0, 32'd0));
    go(mk(OpMov, 5'd7, 5'd0, 12'd0, 7'd0, 32'h12345678));
    random_run(120);
    drain();

    write_plen(ProgramWords);
    random_run(120);
    go(mk(OpJmp, 5'd0, 5'd0, 12'd0, 7'd0, 32'd0));
    drain();

    write_plen($urandom_range(16, 600));
    random_run(120);
    drain();

    // one error ends the program; the pick varies with the seed
    err_sel = $urandom_range(0, 9);
    go(mk(OpMov, 5'd3, 5'd0, 12'd0, 7'd0, 32'h7fffffff));
    go(mk(OpMov, 5'd4, 5'd0, 12'd0, 7'd0, 32'h80000000));
    go(mk(OpMov, 5'd6, 5'd0, 12'd0, 7'd0, 32'd1));
    go(mk(OpMov, 5'd8, 5'd0, 12'd0, 7'd0, 32'd0));
    go(mk(OpMov, 5'd9, 5'd0, 12'd0, 7'd0, 32'hffffffff));
    case (err_sel)
      0: issue_raw(mk(OpHalt, 5'd0, 5'd0, 12'd0, 7'd0, 32'd0));
      1: begin
        while (depth_m < StackDepth) go(mk(OpPush, 5'($urandom), 5'd0, 12'd0, 7'd0, 32'd0));
        go(mk(OpPrint, 5'd0, 5'd0, 12'd0, 7'(StackDepth), 32'd0));
        issue_raw(mk(($urandom_range(0, 1) ? OpPush : OpCall), 5'd3, 5'd0, 12'd0, 7'd0, 32'd0));
      end
      2: begin
        while (depth_m > 0) go(mk(OpPop, 5'd20, 5'd0, 12'd0, 7'd0, 32'd0));
        issue_raw(mk(OpRet, 5'd0, 5'd0, 12'd0, 7'd0, 32'd0));
      end
      3: issue_raw(mk(OpAdd, 5'd3, 5'd6, 12'd0, 7'd0, 32'd0));
      4: issue_raw(mk(OpSub, 5'd4, 5'd6, 12'd0, 7'd0, 32'd0));
      5: issue_raw(mk(OpDiv, 5'd3, 5'd8, 12'd0, 7'd0, 32'd0));
      6: issue_raw(mk(OpDiv, 5'd4, 5'd9, 12'd0, 7'd0, 32'd0));
      7: begin
        it = instr_t'({$urandom, $urandom, $urandom});
        while (known_op(it.op)) it.op = 6'($urandom);
        issue_raw(it);
      end
      8: issue_raw(mk(OpPrint, 5'd0, 5'd0, 12'd0, 7'($urandom_range(depth_m + 1, 127)), 32'd0));
      default: begin
        drain();
        write_plen(ip_m);
        issue_raw(instr_t'({$urandom, $urandom, $urandom}));
      end
    endcase
    repeat (12) issue_raw(instr_t'({$urandom, $urandom, $urandom}));
    drain();
    write_plen(0);
    repeat (4) issue_raw(instr_t'({$urandom, $urandom, $urandom}));
    drain();
    repeat (50) @(posedge clk_i);

    $display("ran %0d instructions, checked %0d results, %0d full-stack prints",
             n_items, n_results, n_full_prints);
    $display("machine stopped on error case %0d, then ran halted with program length 0",
             err_sel);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("stack_machine_instruction_executor_unit test passed");
    end else begin
      $display("stack_machine_instruction_executor_unit test failed");
    end
    $finish;
  end

endmodule
